/* sv/nor_flash_word_program_sequencer_core_defines.svh */
// ----------------------------------------------------------------------------
// NOR flash word program sequencer: assertion macros
// Shared property macros for the sequencer's in-module checks.
// ----------------------------------------------------------------------------
`ifndef NOR_FLASH_WORD_PROGRAM_SEQUENCER_CORE_DEFINES_SVH
`define NOR_FLASH_WORD_PROGRAM_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define NFWPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfwps assertion failed");

// next-cycle implication
`define NFWPS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nfwps assertion failed");

`endif

/* sv/nfwps_pkg.sv */
// ----------------------------------------------------------------------------
// NOR flash word program sequencer: package
// Payload types, codes and command constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package nfwps_pkg;

   localparam int AddressBits  = 22;
   localparam int DataBits     = 16;
   localparam int TickBits     = 16;
   localparam int QueueDepth   = 4;   // power of two
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      OP_PROGRAM = 2'd0,
      OP_POLL    = 2'd1,
      OP_TICK    = 2'd2
   } op_type;

   localparam logic [2:0] StatusOk      = 3'd0;
   localparam logic [2:0] StatusRefused = 3'd1;
   localparam logic [2:0] StatusFailed  = 3'd2;
   localparam logic [2:0] StatusBusy    = 3'd3;
   localparam logic [2:0] StatusIgnored = 3'd4;

   localparam logic KindWrite  = 1'b0;
   localparam logic KindReport = 1'b1;

   localparam logic CsrProtectLimit = 1'b0;
   localparam logic CsrTimeoutTicks = 1'b1;

   localparam logic [AddressBits-1:0] UnlockAddr1 = AddressBits'(12'hAAA);
   localparam logic [AddressBits-1:0] UnlockAddr2 = AddressBits'(12'h554);
   localparam logic [DataBits-1:0]    UnlockData1 = 16'hAAAA;
   localparam logic [DataBits-1:0]    UnlockData2 = 16'h5555;
   localparam logic [DataBits-1:0]    CmdProgram  = 16'hA0A0;
   localparam logic [DataBits-1:0]    CmdReset    = 16'h00F0;

   typedef struct packed {
      logic [1:0]             operation;
      logic [AddressBits-1:0] address;
      logic [DataBits-1:0]    data_word;
      logic [DataBits-1:0]    status_again;
   } req_type;

   typedef struct packed {
      logic                   kind;
      logic [AddressBits-1:0] bus_address;
      logic [DataBits-1:0]    bus_data;
      logic [2:0]             status;
      logic                   last;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_REPORT  = 2'd0,
      JOB_PROGRAM = 2'd1,
      JOB_FAIL    = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type           job_kind;
      logic [AddressBits-1:0] address;
      logic [DataBits-1:0]    data;
      logic [2:0]             status;
   } job_type;

   function automatic rsp_type make_write(logic [AddressBits-1:0] addr,
                                          logic [DataBits-1:0] data, logic last);
      rsp_type r;
      r.kind        = KindWrite;
      r.bus_address = addr;
      r.bus_data    = data;
      r.status      = StatusOk;
      r.last        = last;
      return r;
   endfunction

   function automatic rsp_type make_report(logic [2:0] status);
      rsp_type r;
      r.kind        = KindReport;
      r.bus_address = '0;
      r.bus_data    = '0;
      r.status      = status;
      r.last        = 1'b1;
      return r;
   endfunction

endpackage

/* sv/nfwps_front.sv */
// ----------------------------------------------------------------------------
// NOR flash word program sequencer: front end
// Holds CSRs and state; turns each request but a non-expiring tick into a job.
// ----------------------------------------------------------------------------
`include "nor_flash_word_program_sequencer_core_defines.svh"

module nfwps_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  nfwps_pkg::req_type                 req_payload,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [nfwps_pkg::AddressBits-1:0]  csr_write_data,
   output logic                               job_push,
   output nfwps_pkg::job_type                 job,
   input  logic                               queue_full
);

   logic                               busy_ff, busy_in;
   logic [nfwps_pkg::AddressBits-1:0]  target_ff, target_in;
   logic                               dq7_ff, dq7_in;
   logic [nfwps_pkg::TickBits-1:0]     ticks_ff, ticks_in;
   logic [nfwps_pkg::AddressBits-1:0]  limit_ff;
   logic [nfwps_pkg::TickBits-1:0]     timeout_ff;
   logic [nfwps_pkg::TickBits-1:0]     ticks_dec;
   logic                               job_valid;
   logic                               accept;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;
   assign job_push = accept && job_valid;
   assign ticks_dec = (ticks_ff == '0) ? '0 : ticks_ff - 1'b1;

   always_comb begin
      busy_in      = busy_ff;
      target_in    = target_ff;
      dq7_in       = dq7_ff;
      ticks_in     = ticks_ff;
      job_valid    = 1'b1;
      job.job_kind = nfwps_pkg::JOB_REPORT;
      job.address  = target_ff;
      job.data     = req_payload.data_word;
      job.status   = nfwps_pkg::StatusIgnored;
      case (nfwps_pkg::op_type'(req_payload.operation))
         nfwps_pkg::OP_PROGRAM: begin
            if (busy_ff) begin
               job.status = nfwps_pkg::StatusIgnored;
            end else if (req_payload.address < limit_ff) begin
               job.status = nfwps_pkg::StatusRefused;
            end else begin
               job.job_kind = nfwps_pkg::JOB_PROGRAM;
               job.address  = req_payload.address;
               busy_in      = 1'b1;
               target_in    = req_payload.address;
               dq7_in       = req_payload.data_word[7];
               ticks_in     = timeout_ff;
            end
         end
         nfwps_pkg::OP_POLL: begin
            if (!busy_ff) begin
               job.status = nfwps_pkg::StatusIgnored;
            end else if (req_payload.data_word[7] == dq7_ff ||
                         (req_payload.data_word[5] &&
                          req_payload.status_again[7] == dq7_ff)) begin
               job.status = nfwps_pkg::StatusOk;
               busy_in    = 1'b0;
               ticks_in   = '0;
            end else if (req_payload.data_word[5] || ticks_ff == '0) begin
               job.job_kind = nfwps_pkg::JOB_FAIL;
               busy_in      = 1'b0;
               ticks_in     = '0;
            end else begin
               job.status = nfwps_pkg::StatusBusy;
            end
         end
         nfwps_pkg::OP_TICK: begin
            if (!busy_ff) begin
               job.status = nfwps_pkg::StatusIgnored;
            end else if (ticks_dec == '0) begin
               job.job_kind = nfwps_pkg::JOB_FAIL;
               busy_in      = 1'b0;
               ticks_in     = '0;
            end else begin
               job_valid = 1'b0;
               ticks_in  = ticks_dec;
            end
         end
         default: begin
            job.status = nfwps_pkg::StatusIgnored;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         target_ff  <= '0;
         dq7_ff     <= 1'b0;
         ticks_ff   <= '0;
         limit_ff   <= '0;
         timeout_ff <= nfwps_pkg::TickBits'(2);
      end else begin
         if (accept) begin
            busy_ff   <= busy_in;
            target_ff <= target_in;
            dq7_ff    <= dq7_in;
            ticks_ff  <= ticks_in;
         end
         if (csr_write_enable) begin
            case (csr_index)
               nfwps_pkg::CsrProtectLimit: limit_ff   <= csr_write_data;
               nfwps_pkg::CsrTimeoutTicks:
                  timeout_ff <= csr_write_data[nfwps_pkg::TickBits-1:0];
               default: limit_ff <= limit_ff;
            endcase
         end
      end
   end

   `NFWPS_ASSERT_IMP(a_idle_no_ticks, clock, reset, !busy_ff, ticks_ff == '0)

endmodule

/* sv/nfwps_queue.sv */
// ----------------------------------------------------------------------------
// NOR flash word program sequencer: job queue
// Short FIFO of classified jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`include "nor_flash_word_program_sequencer_core_defines.svh"

module nfwps_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nfwps_pkg::job_type  push_job,
   output logic                full,
   input  logic                pop,
   output nfwps_pkg::job_type  head_job,
   output logic                empty
);

   nfwps_pkg::job_type                   slots_ff [nfwps_pkg::QueueDepth];
   logic [nfwps_pkg::QueuePtrBits-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [nfwps_pkg::QueueCntBits-1:0]   count_ff;
   logic                                 do_push, do_pop;

   assign full     = (count_ff == nfwps_pkg::QueueCntBits'(nfwps_pkg::QueueDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `NFWPS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
                     count_ff <= nfwps_pkg::QueueCntBits'(nfwps_pkg::QueueDepth))

endmodule

/* sv/nfwps_back.sv */
// ----------------------------------------------------------------------------
// NOR flash word program sequencer: back end
// Expands queued jobs into bus writes and reports through an output register.
// ----------------------------------------------------------------------------
`include "nor_flash_word_program_sequencer_core_defines.svh"

module nfwps_back (
   input  logic                clock,
   input  logic                reset,
   input  nfwps_pkg::job_type  head_job,
   input  logic                head_empty,
   output logic                head_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output nfwps_pkg::rsp_type  rsp_payload
);

   logic [1:0]          step_ff;
   logic                out_valid_ff;
   nfwps_pkg::rsp_type  out_ff;
   nfwps_pkg::rsp_type  beat;
   logic                load;

   assign rsp_empty   = !out_valid_ff;
   assign rsp_payload = out_ff;
   assign load        = !head_empty && (!out_valid_ff || rsp_pop);
   assign head_pop    = load && beat.last;

   always_comb begin
      case (head_job.job_kind)
         nfwps_pkg::JOB_PROGRAM: begin
            case (step_ff)
               2'd0: beat = nfwps_pkg::make_write(nfwps_pkg::UnlockAddr1,
                                                  nfwps_pkg::UnlockData1, 1'b0);
               2'd1: beat = nfwps_pkg::make_write(nfwps_pkg::UnlockAddr2,
                                                  nfwps_pkg::UnlockData2, 1'b0);
               2'd2: beat = nfwps_pkg::make_write(nfwps_pkg::UnlockAddr1,
                                                  nfwps_pkg::CmdProgram, 1'b0);
               default: beat = nfwps_pkg::make_write(head_job.address,
                                                     head_job.data, 1'b1);
            endcase
         end
         nfwps_pkg::JOB_FAIL: begin
            if (step_ff == 2'd0) begin
               beat = nfwps_pkg::make_write(head_job.address, nfwps_pkg::CmdReset, 1'b0);
            end else begin
               beat = nfwps_pkg::make_report(nfwps_pkg::StatusFailed);
            end
         end
         default: begin
            beat = nfwps_pkg::make_report(head_job.status);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
            step_ff      <= beat.last ? 2'd0 : step_ff + 2'd1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   `NFWPS_ASSERT_IMP(a_step_has_job, clock, reset, step_ff != 2'd0, !head_empty)
   `NFWPS_ASSERT_IMP(a_report_is_last, clock, reset,
                     out_valid_ff && out_ff.kind == nfwps_pkg::KindReport, out_ff.last)

endmodule

/* sv/nor_flash_word_program_sequencer_core.sv */
// ----------------------------------------------------------------------------
// NOR flash word program sequencer core
// Word program command issue with DQ7 data polling and tick timeout.
// ----------------------------------------------------------------------------
// channel   ports                              moves
// request   req_push / req_full / req_payload  program, poll or tick
// response  rsp_empty / rsp_pop / rsp_payload  bus write or status report
// csr       csr_write_enable / csr_index / _data  protect limit, timeout
//
// A request is classified in its accept cycle; results leave the output
// register one per cycle unless rsp_pop stalls: a program gives 4, others 0 to 2.
// A 4-entry job queue decouples the front end from the response side.
// req_full is high while the job queue holds 4 jobs; rsp_pop stalls back into it.
// reset (synchronous) clears state; protect limit 0, timeout 2 ticks.
// ----------------------------------------------------------------------------
module nor_flash_word_program_sequencer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  nfwps_pkg::req_type                 req_payload,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output nfwps_pkg::rsp_type                 rsp_payload,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [nfwps_pkg::AddressBits-1:0]  csr_write_data
);

   logic                job_push, queue_full, head_empty, head_pop;
   nfwps_pkg::job_type  job, head_job;

   nfwps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .job_push         (job_push),
      .job              (job),
      .queue_full       (queue_full)
   );

   nfwps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .full     (queue_full),
      .pop      (head_pop),
      .head_job (head_job),
      .empty    (head_empty)
   );

   nfwps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .head_empty  (head_empty),
      .head_pop    (head_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

/* bench/nor_flash_word_program_sequencer_core_tb.sv */
// ----------------------------------------------------------------------------
// NOR flash word program sequencer core: testbench
// Directed and random program, poll and tick requests against a scoreboard
// that tracks the command sequence, DQ7/DQ5 status decode and tick timeout.
// Both queue sides idle at random; registers change only between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nor_flash_word_program_sequencer_core_tb;

   localparam logic [1:0]  OpUnknown       = 2'd3;
   localparam logic [21:0] AddrMax         = 22'h3FFFFF;
   localparam logic [21:0] FirstUnlockAdr  = 22'hAAA;
   localparam logic [21:0] SecondUnlockAdr = 22'h554;
   localparam logic [15:0] FirstUnlockDat  = 16'hAAAA;
   localparam logic [15:0] SecondUnlockDat = 16'h5555;
   localparam logic [15:0] ProgramCommand  = 16'hA0A0;
   localparam logic [15:0] ResetCommand    = 16'h00F0;
   localparam logic [15:0] Dq7Mask         = 16'h0080;
   localparam logic [15:0] Dq5Mask         = 16'h0020;

   class word_program_scoreboard;
      logic [21:0]         protect_limit;
      logic [15:0]         timeout_ticks;
      bit                  busy;
      logic [21:0]         target_address;
      bit                  expected_dq7;
      logic [15:0]         ticks_left;
      nfwps_pkg::rsp_type  bus_results_due[$];
      int                  mismatches;

      function new();
         protect_limit  = '0;
         timeout_ticks  = 16'd2;
         busy           = 1'b0;
         target_address = '0;
         expected_dq7   = 1'b0;
         ticks_left     = '0;
         mismatches     = 0;
      endfunction

      function void set_register(logic index, logic [21:0] value);
         if (index == nfwps_pkg::CsrProtectLimit)
            protect_limit = value;
         else
            timeout_ticks = value[15:0];
      endfunction

      function void add_write(logic [21:0] addr, logic [15:0] data, logic last);
         nfwps_pkg::rsp_type r;
         r.kind        = nfwps_pkg::KindWrite;
         r.bus_address = addr;
         r.bus_data    = data;
         r.status      = nfwps_pkg::StatusOk;
         r.last        = last;
         bus_results_due.push_back(r);
      endfunction

      function void add_report(logic [2:0] status);
         nfwps_pkg::rsp_type r;
         r.kind        = nfwps_pkg::KindReport;
         r.bus_address = '0;
         r.bus_data    = '0;
         r.status      = status;
         r.last        = 1'b1;
         bus_results_due.push_back(r);
      endfunction

      function void abort_program();
         add_write(target_address, ResetCommand, 1'b0);
         add_report(nfwps_pkg::StatusFailed);
         busy       = 1'b0;
         ticks_left = '0;
      endfunction

      function void end_ok();
         add_report(nfwps_pkg::StatusOk);
         busy       = 1'b0;
         ticks_left = '0;
      endfunction

      function void note_request(nfwps_pkg::req_type rq);
         case (rq.operation)
            nfwps_pkg::OP_PROGRAM: begin
               if (busy)
                  add_report(nfwps_pkg::StatusIgnored);
               else if (rq.address < protect_limit)
                  add_report(nfwps_pkg::StatusRefused);
               else begin
                  add_write(FirstUnlockAdr, FirstUnlockDat, 1'b0);
                  add_write(SecondUnlockAdr, SecondUnlockDat, 1'b0);
                  add_write(FirstUnlockAdr, ProgramCommand, 1'b0);
                  add_write(rq.address, rq.data_word, 1'b1);
                  busy           = 1'b1;
                  target_address = rq.address;
                  expected_dq7   = rq.data_word[7];
                  ticks_left     = timeout_ticks;
               end
            end
            nfwps_pkg::OP_POLL: begin
               if (!busy)
                  add_report(nfwps_pkg::StatusIgnored);
               else if (rq.data_word[7] == expected_dq7)
                  end_ok();
               else if ((rq.data_word & Dq5Mask) != 0) begin
                  if (rq.status_again[7] == expected_dq7)
                     end_ok();
                  else
                     abort_program();
               end
               else if (ticks_left == 0)
                  abort_program();
               else
                  add_report(nfwps_pkg::StatusBusy);
            end
            nfwps_pkg::OP_TICK: begin
               if (!busy)
                  add_report(nfwps_pkg::StatusIgnored);
               else begin
                  if (ticks_left > 0)
                     ticks_left = ticks_left - 1'b1;
                  if (ticks_left == 0)
                     abort_program();
               end
            end
            default: add_report(nfwps_pkg::StatusIgnored);
         endcase
      endfunction

      function void flag(string what, nfwps_pkg::rsp_type want, nfwps_pkg::rsp_type got);
         string exp_s;
         string got_s;
         mismatches++;
         exp_s = $sformatf("kind=%0d addr=%h data=%h st=%0d last=%0d", want.kind,
                           want.bus_address, want.bus_data, want.status, want.last);
         got_s = $sformatf("kind=%0d addr=%h data=%h st=%0d last=%0d", got.kind,
                           got.bus_address, got.bus_data, got.status, got.last);
         if (mismatches <= 10)
            $display("[%0t] %s: exp %s | got %s", $realtime, what, exp_s, got_s);
      endfunction

      function void check_result(nfwps_pkg::rsp_type got);
         nfwps_pkg::rsp_type want;
         if (bus_results_due.size() == 0) begin
            flag("unexpected transaction", '0, got);
            return;
         end
         want = bus_results_due.pop_front();
         if (got.kind !== want.kind || got.bus_address !== want.bus_address ||
             got.bus_data !== want.bus_data || got.status !== want.status ||
             got.last !== want.last)
            flag("mismatch", want, got);
      endfunction

      function void check_drained();
         while (bus_results_due.size() != 0)
            flag("missing transaction", bus_results_due.pop_front(), '0);
      endfunction
   endclass

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_push         = 1'b0;
   logic                req_full;
   nfwps_pkg::req_type  req_payload      = '0;
   logic                rsp_empty;
   logic                rsp_pop          = 1'b0;
   nfwps_pkg::rsp_type  rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic                csr_index        = 1'b0;
   logic [21:0]         csr_write_data   = '0;

   word_program_scoreboard sb;

   int req_gap  = 0;
   int req_run  = 0;
   bit req_calm = 1'b0;
   int rsp_run  = 0;
   bit rsp_calm = 1'b0;

   nor_flash_word_program_sequencer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_payload      (req_payload),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int draw_gap(inout int left, inout bit calm);
      if (left == 0) begin
         left = $urandom_range(4, 24);
         calm = ($urandom_range(0, 3) == 0);
      end
      left--;
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [21:0] addr,
                               input logic [15:0] word, input logic [15:0] again);
      nfwps_pkg::req_type item;
      item.operation    = op;
      item.address      = addr;
      item.data_word    = word;
      item.status_again = again;
      if (req_gap > 0)
         repeat (req_gap) @(posedge clock);
      req_payload <= item;
      req_push    <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_request(item);
      req_gap = draw_gap(req_run, req_calm);
      if (req_gap > 0)
         req_push <= 1'b0;
   endtask

   // close any open program, stop pushing, then drain all expected transactions
   task automatic settle();
      if (sb.busy)
         send_request(nfwps_pkg::OP_POLL, 22'($urandom),
                      {8'h00, sb.expected_dq7, 7'h00}, 16'($urandom));
      if (req_gap == 0) begin
         req_push <= 1'b0;
         req_gap = 1;
      end
      while (sb.bus_results_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [21:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      sb.set_register(index, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int          rsp_gap;
      wait (reset == 1'b0);
      @(posedge clock);
      rsp_pop <= 1'b1;
      forever begin
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         sb.check_result(rsp_payload);
         rsp_gap = draw_gap(rsp_run, rsp_calm);
         if (rsp_gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (rsp_gap) @(posedge clock);
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      int          counted;
      int          roll;
      logic [1:0]  op;
      logic [21:0] addr;
      logic [15:0] word;

      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // requests outside a program, then ok, second-read, DQ5 fail and timeout
      send_request(nfwps_pkg::OP_POLL, '0, 16'hFFFF, 16'hFFFF);
      send_request(nfwps_pkg::OP_TICK, '0, 16'h0000, 16'h0000);
      send_request(OpUnknown, AddrMax, 16'hFFFF, 16'hFFFF);
      send_request(nfwps_pkg::OP_PROGRAM, '0, 16'hFFFF, 16'h0000);
      send_request(nfwps_pkg::OP_PROGRAM, 22'h0ABCDE, 16'h1234, 16'h0000);
      send_request(nfwps_pkg::OP_POLL, '0, 16'h0000, 16'hFFFF);
      send_request(OpUnknown, '0, 16'h0000, 16'h0000);
      send_request(nfwps_pkg::OP_POLL, AddrMax, 16'h0080, 16'h0000);
      send_request(nfwps_pkg::OP_PROGRAM, AddrMax, 16'h0000, 16'hFFFF);
      send_request(nfwps_pkg::OP_POLL, '0, 16'h00A0, 16'h0000);
      send_request(nfwps_pkg::OP_PROGRAM, 22'h123456, 16'h5A5A, 16'h0000);
      send_request(nfwps_pkg::OP_POLL, '0, 16'h00A0, 16'hFFFF);
      send_request(nfwps_pkg::OP_PROGRAM, 22'h000001, 16'h0080, 16'h0000);
      send_request(nfwps_pkg::OP_TICK, '0, 16'h0000, 16'h0000);
      send_request(nfwps_pkg::OP_TICK, '0, 16'h0000, 16'h0000);
      settle();

      write_csr(nfwps_pkg::CsrProtectLimit, 22'h200000);
      write_csr(nfwps_pkg::CsrTimeoutTicks, 22'h000000);
      send_request(nfwps_pkg::OP_PROGRAM, 22'h1FFFFF, 16'hFFFF, 16'h0000);
      send_request(nfwps_pkg::OP_PROGRAM, 22'h200000, 16'h7F7F, 16'h0000);
      send_request(nfwps_pkg::OP_POLL, '0, 16'h0080, 16'h0000);
      send_request(nfwps_pkg::OP_PROGRAM, AddrMax, 16'hFFFF, 16'h0000);
      send_request(nfwps_pkg::OP_TICK, '0, 16'h0000, 16'h0000);
      settle();

      write_csr(nfwps_pkg::CsrProtectLimit, AddrMax);
      write_csr(nfwps_pkg::CsrTimeoutTicks, 22'h00FFFF);
      send_request(nfwps_pkg::OP_PROGRAM, 22'h3FFFFE, 16'h0000, 16'h0000);
      send_request(nfwps_pkg::OP_PROGRAM, AddrMax, 16'h8000, 16'h0000);
      send_request(nfwps_pkg::OP_POLL, '0, 16'h0080, 16'h0000);
      send_request(nfwps_pkg::OP_POLL, '0, 16'h0000, 16'h0000);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_csr(nfwps_pkg::CsrProtectLimit, 22'($urandom_range(0, AddrMax)));
               write_csr(nfwps_pkg::CsrTimeoutTicks, 22'($urandom_range(1, 4)));
            end
            1: begin
               write_csr(nfwps_pkg::CsrProtectLimit, '0);
               write_csr(nfwps_pkg::CsrTimeoutTicks, 22'h00FFFF);
            end
            2: begin
               write_csr(nfwps_pkg::CsrProtectLimit, 22'($urandom_range(0, AddrMax)));
               write_csr(nfwps_pkg::CsrTimeoutTicks, '0);
            end
            default: begin
               write_csr(nfwps_pkg::CsrProtectLimit, 22'($urandom_range(0, 22'h00FFFF)));
               write_csr(nfwps_pkg::CsrTimeoutTicks, 22'($urandom_range(2, 6)));
            end
         endcase
         counted = 0;
         while (counted < 34) begin
            roll  = $urandom_range(0, 99);
            addr  = 22'($urandom_range(0, AddrMax));
            word  = 16'($urandom);
            if (!sb.busy) begin
               if (roll < 70) begin
                  op = nfwps_pkg::OP_PROGRAM;
                  if (sb.protect_limit != 0 && $urandom_range(0, 9) == 0)
                     addr = 22'($urandom_range(0, sb.protect_limit - 1));
                  else
                     addr = 22'($urandom_range(sb.protect_limit, AddrMax));
               end
               else if (roll < 80) op = nfwps_pkg::OP_POLL;
               else if (roll < 90) op = nfwps_pkg::OP_TICK;
               else                op = OpUnknown;
            end
            else begin
               if (roll < 50) begin
                  op = nfwps_pkg::OP_POLL;
                  if ($urandom_range(0, 3) == 0)
                     word = word | Dq5Mask;
                  else if ($urandom_range(0, 2) == 0)
                     word = word & ~Dq5Mask;
               end
               else if (roll < 85) op = nfwps_pkg::OP_TICK;
               else if (roll < 95) op = nfwps_pkg::OP_PROGRAM;
               else                op = OpUnknown;
            end
            send_request(op, addr, word, 16'($urandom));
            counted++;
         end
         settle();
      end

      sb.check_drained();
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
